// ===== rtl/dual_channel_dds_sine_source_defines.svh =====
// Assertion macros used by the checker file of the sine source
`ifndef DUAL_CHANNEL_DDS_SINE_SOURCE_DEFINES_SVH
`define DUAL_CHANNEL_DDS_SINE_SOURCE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define DDS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("sine source check failed");

// Next-cycle implication, disabled while reset is low
`define DDS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("sine source check failed");

`endif

// ===== rtl/dds_src_pkg.sv =====
// Types, constants and the sine ROM contents of the dual channel sine source
package dds_src_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 1024;
  localparam int PHASE_W       = 32;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  // Codes and amplitudes
  localparam int CODE_W  = 12;
  localparam int PEAK_W  = 11;
  localparam int MODE_W  = 2;
  localparam int SAMPLE_W = 16;
  localparam logic [CODE_W-1:0] MID_CODE = 12'd2048;
  localparam logic [CODE_W-1:0] CODE_MAX = 12'd4095;
  localparam logic [PEAK_W-1:0] MAX_PEAK = 11'd2047;

  // Scaling datapath: magnitude times peak, then divide by MAX_PEAK
  localparam int MAG_W   = CODE_W;
  localparam int PROD_W  = MAG_W + PEAK_W;
  localparam int QUO_W   = CODE_W;
  localparam int DIV_SHIFT = 33;
  localparam int RECIP_W = 23;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'((64'd1 << DIV_SHIFT) / 64'(MAX_PEAK));
  localparam int NUM_CH  = 2;
  localparam int CH_TEST = 0;
  localparam int CH_REF  = 1;

  // Command queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_PEAK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEST_PEAK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEST_OFFSET = 3'd4;

  // Mode codes; the unused code behaves as stop
  localparam logic [MODE_W-1:0] MODE_STOP   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SYNTH  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STREAM = 2'd2;

  typedef enum logic [1:0] {
    KIND_MID    = 2'd0,
    KIND_SINE   = 2'd1,
    KIND_STREAM = 2'd2
  } kind_e;

  typedef struct packed {
    logic                restart;
    logic [SAMPLE_W-1:0] stream_sample;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] test_code;
    logic [CODE_W-1:0] ref_code;
  } out_item_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [PHASE_W-1:0] phase_step;
    logic [PEAK_W-1:0]  ref_peak;
    logic [PEAK_W-1:0]  test_peak;
    logic [PHASE_W-1:0] test_phase_offset;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  test_idx;
    logic [IDX_W-1:0]  ref_idx;
    logic [CODE_W-1:0] stream_code;
  } cmd_t;

  typedef logic [CODE_W-1:0] sine_rom_t [TABLE_ENTRIES];

  localparam int Q_BITS = 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // sin(pi/2 * r / TABLE_ENTRIES) in Q30 by a Taylor series
  function automatic longint quarter_sine(int unsigned r);
    longint unsigned t;
    longint unsigned term;
    longint          sum;
    int              k;
    t    = (HALF_PI_Q30 * 64'(r)) / 64'(TABLE_ENTRIES);
    term = t;
    sum  = longint'(t);
    for (k = 1; k <= 9; k++) begin
      term = (term * t) >> Q_BITS;
      term = (term * t) >> Q_BITS;
      case (k)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        6: term = term / 64'd156;
        7: term = term / 64'd210;
        8: term = term / 64'd272;
        default: term = term / 64'd342;
      endcase
      if ((k % 2) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return sum;
  endfunction

  // Rounded sine codes centered on the mid code
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    int unsigned     i;
    int unsigned     u;
    int unsigned     q;
    int unsigned     r;
    longint          s;
    longint          v;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      u = 4 * i;
      q = u / TABLE_ENTRIES;
      r = u % TABLE_ENTRIES;
      if ((q % 2) != 0) begin
        s = quarter_sine(TABLE_ENTRIES - r);
      end else begin
        s = quarter_sine(r);
      end
      if (q >= 2) begin
        s = -s;
      end
      v = longint'(MID_CODE) * (64'sd1 <<< Q_BITS) + longint'(MAX_PEAK) * s
          + (64'sd1 <<< (Q_BITS - 1));
      if (v < 0) begin
        v = 0;
      end
      v = longint'($unsigned(v) >> Q_BITS);
      if (v > longint'(CODE_MAX)) begin
        v = longint'(CODE_MAX);
      end
      rom[i] = v[CODE_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ===== rtl/dds_src_cfg.sv =====
// Configuration register file of the sine source
module dds_src_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dds_src_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dds_src_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output dds_src_pkg::cfg_t                   cfg_o
);

  dds_src_pkg::cfg_t cfg_q;

  // Accept a write in every cycle
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode the index and update one register; drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dds_src_pkg::REG_MODE:
          cfg_q.mode <= cfg_data_i[dds_src_pkg::MODE_W-1:0];
        dds_src_pkg::REG_PHASE_STEP:
          cfg_q.phase_step <= cfg_data_i[dds_src_pkg::PHASE_W-1:0];
        dds_src_pkg::REG_REF_PEAK:
          cfg_q.ref_peak <= cfg_data_i[dds_src_pkg::PEAK_W-1:0];
        dds_src_pkg::REG_TEST_PEAK:
          cfg_q.test_peak <= cfg_data_i[dds_src_pkg::PEAK_W-1:0];
        dds_src_pkg::REG_TEST_OFFSET:
          cfg_q.test_phase_offset <= cfg_data_i[dds_src_pkg::PHASE_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/dds_src_front.sv =====
// Front end: accepts sample ticks, advances the phases and issues commands
module dds_src_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dds_src_pkg::cfg_t     cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  dds_src_pkg::in_item_t in_data_i,
  output logic                  push_o,
  output dds_src_pkg::cmd_t     cmd_o,
  input  logic                  full_i
);

  logic [dds_src_pkg::PHASE_W-1:0] ref_phase_q, ref_phase_d;
  logic [dds_src_pkg::PHASE_W-1:0] test_phase_q, test_phase_d;
  logic [dds_src_pkg::PHASE_W-1:0] ref_base;
  logic [dds_src_pkg::PHASE_W-1:0] test_base;
  logic                            synth;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Reload on restart, then classify the tick by mode
  always_comb begin
    ref_base  = in_data_i.restart ? '0 : ref_phase_q;
    test_base = in_data_i.restart ? cfg_i.test_phase_offset : test_phase_q;
    synth     = 1'b0;

    cmd_o.test_idx    = test_base[dds_src_pkg::PHASE_W-1 -: dds_src_pkg::IDX_W];
    cmd_o.ref_idx     = ref_base[dds_src_pkg::PHASE_W-1 -: dds_src_pkg::IDX_W];
    cmd_o.stream_code = in_data_i.stream_sample[dds_src_pkg::CODE_W-1:0];
    case (cfg_i.mode)
      dds_src_pkg::MODE_SYNTH: begin
        cmd_o.kind = dds_src_pkg::KIND_SINE;
        synth      = 1'b1;
      end
      dds_src_pkg::MODE_STREAM: cmd_o.kind = dds_src_pkg::KIND_STREAM;
      dds_src_pkg::MODE_STOP:   cmd_o.kind = dds_src_pkg::KIND_MID;
      default:                  cmd_o.kind = dds_src_pkg::KIND_MID;
    endcase

    // Advance only in synthesis, after the sample phase is taken
    ref_phase_d  = synth ? ref_base + cfg_i.phase_step : ref_base;
    test_phase_d = synth ? test_base + cfg_i.phase_step : test_base;
  end

  // Hold the accumulators between transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_phase_q  <= '0;
      test_phase_q <= '0;
    end else if (push_o) begin
      ref_phase_q  <= ref_phase_d;
      test_phase_q <= test_phase_d;
    end
  end

endmodule

// ===== rtl/dds_src_fifo.sv =====
// Short command queue between the front end and the back end
module dds_src_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dds_src_pkg::cmd_t cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output dds_src_pkg::cmd_t cmd_o
);

  localparam int PtrW = dds_src_pkg::FIFO_PTR_W;

  dds_src_pkg::cmd_t mem_q [dds_src_pkg::FIFO_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [PtrW:0]     count_q;
  logic              do_pop;

  assign full_o  = (count_q == (PtrW+1)'(dds_src_pkg::FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== rtl/dds_src_back.sv =====
// Back end: sine ROM lookup, amplitude scaling and the output register
module dds_src_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dds_src_pkg::cfg_t      cfg_i,
  input  logic                   cmd_valid_i,
  input  dds_src_pkg::cmd_t      cmd_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output dds_src_pkg::out_item_t out_data_o
);

  localparam int NCh   = dds_src_pkg::NUM_CH;
  localparam int CodeW = dds_src_pkg::CODE_W;
  localparam int ProdW = dds_src_pkg::PROD_W;
  localparam int QuoW  = dds_src_pkg::QUO_W;
  localparam int WideW = dds_src_pkg::PROD_W + dds_src_pkg::RECIP_W;

  logic en;

  // Stage A: ROM data
  logic                   va_q;
  dds_src_pkg::kind_e     kind_a_q;
  logic [CodeW-1:0]       stream_a_q;
  logic [CodeW-1:0]       rom_q [NCh];

  // Stage B: magnitude times peak
  logic                   vb_q;
  dds_src_pkg::kind_e     kind_b_q;
  logic [CodeW-1:0]       stream_b_q;
  logic [ProdW-1:0]       prod_b_q [NCh];
  logic                   neg_b_q [NCh];

  // Stage C: estimated quotient
  logic                   vc_q;
  dds_src_pkg::kind_e     kind_c_q;
  logic [CodeW-1:0]       stream_c_q;
  logic [ProdW-1:0]       prod_c_q [NCh];
  logic [QuoW-1:0]        qest_c_q [NCh];
  logic                   neg_c_q [NCh];

  // Output register
  logic                   out_valid_q;
  dds_src_pkg::out_item_t out_data_q;
  dds_src_pkg::out_item_t out_data_d;

  logic [dds_src_pkg::PEAK_W-1:0] peak [NCh];
  logic [dds_src_pkg::MAG_W-1:0]  mag_b [NCh];
  logic [ProdW-1:0]               prod_b_d [NCh];
  logic                           neg_b_d [NCh];
  logic [WideW-1:0]               scaled [NCh];
  logic [QuoW-1:0]                qest_d [NCh];
  logic [ProdW-1:0]               back_mul [NCh];
  logic [ProdW-1:0]               rem [NCh];
  logic [QuoW-1:0]                quo [NCh];
  logic [CodeW:0]                 code_wide [NCh];
  logic [CodeW-1:0]               code [NCh];

  // Move the whole pipe unless the output holds a stalled result
  assign en          = !out_valid_q || out_ready_i;
  assign pop_o       = en && cmd_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign peak[dds_src_pkg::CH_TEST] = cfg_i.test_peak;
  assign peak[dds_src_pkg::CH_REF]  = cfg_i.ref_peak;

  // Signed offset from mid code, as sign and magnitude, times peak
  always_comb begin
    for (int c = 0; c < NCh; c++) begin
      neg_b_d[c] = (rom_q[c] < dds_src_pkg::MID_CODE);
      mag_b[c]   = neg_b_d[c] ? dds_src_pkg::MID_CODE - rom_q[c]
                              : rom_q[c] - dds_src_pkg::MID_CODE;
      prod_b_d[c] = ProdW'(mag_b[c]) * ProdW'(peak[c]);
    end
  end

  // Quotient estimate by reciprocal; it falls short by at most one
  always_comb begin
    for (int c = 0; c < NCh; c++) begin
      scaled[c] = WideW'(prod_b_q[c]) * WideW'(dds_src_pkg::DIV_RECIP);
      qest_d[c] = scaled[c][dds_src_pkg::DIV_SHIFT +: QuoW];
    end
  end

  // Correct the quotient, re-center, clamp, and pick by command kind
  always_comb begin
    for (int c = 0; c < NCh; c++) begin
      back_mul[c] = (ProdW'(qest_c_q[c]) << dds_src_pkg::PEAK_W) - ProdW'(qest_c_q[c]);
      rem[c]      = prod_c_q[c] - back_mul[c];
      quo[c]      = (rem[c] >= ProdW'(dds_src_pkg::MAX_PEAK)) ? qest_c_q[c] + 1'b1
                                                             : qest_c_q[c];
      code_wide[c] = neg_c_q[c]
          ? (CodeW+1)'(dds_src_pkg::MID_CODE) - (CodeW+1)'(quo[c])
          : (CodeW+1)'(dds_src_pkg::MID_CODE) + (CodeW+1)'(quo[c]);
      // Quotient never exceeds the mid code, so only the top needs a clamp
      code[c] = (code_wide[c] > (CodeW+1)'(dds_src_pkg::CODE_MAX))
          ? dds_src_pkg::CODE_MAX : code_wide[c][CodeW-1:0];
    end
    case (kind_c_q)
      dds_src_pkg::KIND_SINE: begin
        out_data_d.test_code = code[dds_src_pkg::CH_TEST];
        out_data_d.ref_code  = code[dds_src_pkg::CH_REF];
      end
      dds_src_pkg::KIND_STREAM: begin
        out_data_d.test_code = stream_c_q;
        out_data_d.ref_code  = dds_src_pkg::MID_CODE;
      end
      default: begin
        out_data_d.test_code = dds_src_pkg::MID_CODE;
        out_data_d.ref_code  = dds_src_pkg::MID_CODE;
      end
    endcase
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      va_q        <= cmd_valid_i;
      vb_q        <= va_q;
      vc_q        <= vb_q;
      out_valid_q <= vc_q;
    end
  end

  // Stage payloads, ROM read registered
  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_a_q   <= cmd_i.kind;
      stream_a_q <= cmd_i.stream_code;
      rom_q[dds_src_pkg::CH_TEST] <= dds_src_pkg::SINE_ROM[cmd_i.test_idx];
      rom_q[dds_src_pkg::CH_REF]  <= dds_src_pkg::SINE_ROM[cmd_i.ref_idx];

      kind_b_q   <= kind_a_q;
      stream_b_q <= stream_a_q;
      kind_c_q   <= kind_b_q;
      stream_c_q <= stream_b_q;
      for (int c = 0; c < NCh; c++) begin
        prod_b_q[c] <= prod_b_d[c];
        neg_b_q[c]  <= neg_b_d[c];
        prod_c_q[c] <= prod_b_q[c];
        qest_c_q[c] <= qest_d[c];
        neg_c_q[c]  <= neg_b_q[c];
      end
      out_data_q <= out_data_d;
    end
  end

endmodule

// ===== rtl/dual_channel_dds_sine_source.sv =====
// Top level of the dual channel sine source: config, front end, queue, back end
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------------------------
//   cfg     | cfg_valid/ready    | cfg_index_i (register), cfg_data_i
//   in      | in_valid/ready     | in_data_i: restart, stream_sample
//   out     | out_valid/ready    | out_data_o: test_code, ref_code
//
// One sample tick is accepted per cycle while the queue is not full; its codes pass
// through the queue, ROM read, multiply by peak, reciprocal multiply and correction.
// The phase add in the front end sets the one-tick-per-cycle rate.
// Reset clears config, phases, queue and stage valids; no fill pass is needed.
// An output stall freezes the back end; the queue keeps taking ticks until full.
module dual_channel_dds_sine_source (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dds_src_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dds_src_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  dds_src_pkg::in_item_t               in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output dds_src_pkg::out_item_t              out_data_o
);

  dds_src_pkg::cfg_t cfg;
  dds_src_pkg::cmd_t push_cmd;
  dds_src_pkg::cmd_t head_cmd;
  logic              push;
  logic              full;
  logic              pop;
  logic              head_valid;

  dds_src_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dds_src_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  dds_src_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .cmd_o   (head_cmd)
  );

  dds_src_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/dds_src_checker.sv =====
// Port-level checker for the sine source, bound to the top level
`include "dual_channel_dds_sine_source_defines.svh"

module dds_src_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_valid_i,
  input logic                                cfg_ready_o,
  input logic [dds_src_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input logic [dds_src_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input dds_src_pkg::out_item_t              out_data_o
);

  // Queue depth plus three stages plus the output register
  localparam logic [3:0] MaxInflight = 4'(dds_src_pkg::FIFO_DEPTH + 4);

  logic [3:0]                      inflight_q;
  logic [dds_src_pkg::MODE_W-1:0]  mode_q;
  logic                            in_xact;
  logic                            out_xact;

  assign in_xact  = in_valid_i && in_ready_o;
  assign out_xact = out_valid_o && out_ready_i;

  // Count transactions accepted but not yet delivered; mirror the mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
      mode_q     <= dds_src_pkg::MODE_STOP;
    end else begin
      case ({in_xact, out_xact})
        2'b10:   inflight_q <= inflight_q + 1'b1;
        2'b01:   inflight_q <= inflight_q - 1'b1;
        default: inflight_q <= inflight_q;
      endcase
      if (cfg_valid_i && cfg_ready_o && cfg_index_i == dds_src_pkg::REG_MODE) begin
        mode_q <= cfg_data_i[dds_src_pkg::MODE_W-1:0];
      end
    end
  end

  `DDS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `DDS_ASSERT_IMPL(a_no_invented, clk_i, rst_ni, out_valid_o, inflight_q != 4'd0)
  `DDS_ASSERT_IMPL(a_bounded, clk_i, rst_ni, 1'b1, inflight_q <= MaxInflight)
  `DDS_ASSERT_IMPL(a_ref_mid, clk_i, rst_ni, out_valid_o && mode_q != dds_src_pkg::MODE_SYNTH, out_data_o.ref_code == dds_src_pkg::MID_CODE)
  `DDS_ASSERT_IMPL(a_stop_mid, clk_i, rst_ni, out_valid_o && mode_q == dds_src_pkg::MODE_STOP, out_data_o.test_code == dds_src_pkg::MID_CODE)

endmodule

bind dual_channel_dds_sine_source dds_src_checker u_dds_src_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_index_i (cfg_index_i),
  .cfg_data_i  (cfg_data_i),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== tb/dual_channel_dds_sine_source_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the dual channel sine source with its own code predictor
module dual_channel_dds_sine_source_test;
  import dds_src_pkg::*;

  localparam logic [MODE_W-1:0]    MODE_UNUSED      = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = 3'd7;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int PRINT_CAP    = 30;
  localparam int RANDOM_TICKS = 880;
  localparam int QUIET_TICKS  = 120;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_data_o;

  // Predictor copy of the registers, the accumulators and the sine table
  logic [MODE_W-1:0]  set_mode = MODE_STOP;
  logic [PHASE_W-1:0] set_step = '0;
  logic [PEAK_W-1:0]  set_ref_peak = '0;
  logic [PEAK_W-1:0]  set_test_peak = '0;
  logic [PHASE_W-1:0] set_offset = '0;
  logic [PHASE_W-1:0] ref_acc = '0;
  logic [PHASE_W-1:0] test_acc = '0;
  logic [CODE_W-1:0]  sine_codes [TABLE_ENTRIES];

  out_item_t   pending_codes [$];
  out_item_t   want_codes;
  int          errors = 0;
  int          ticks_sent = 0;
  int          results_seen = 0;
  int          reg_writes = 0;
  int unsigned idle_cycles = 0;
  int          stall_left = 0;
  bit          gaps_on = 1'b0;
  bit          stalls_on = 1'b0;

  dual_channel_dds_sine_source u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // sin(pi/2 * r / TABLE_ENTRIES) in Q30, truncated Taylor series
  function automatic longint q30_quarter_sine(int unsigned r);
    longint unsigned t;
    longint unsigned term;
    longint          acc;
    int unsigned     k;
    t    = (64'd1686629713 * 64'(r)) / 64'(TABLE_ENTRIES);
    term = t;
    acc  = longint'(t);
    for (k = 1; k <= 9; k++) begin
      term = (term * t) >> 30;
      term = (term * t) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k[0]) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    return acc;
  endfunction

  // Scale one table entry by a peak count, truncating toward zero, then clamp
  function automatic logic [CODE_W-1:0] scaled_code(logic [PHASE_W-1:0] acc,
                                                    logic [PEAK_W-1:0] peak);
    int unit;
    int level;
    unit  = int'(sine_codes[acc[PHASE_W-1 -: IDX_W]]) - int'(MID_CODE);
    level = int'(MID_CODE) + (unit * int'(peak)) / int'(MAX_PEAK);
    if (level < 0) begin
      level = 0;
    end else if (level > int'(CODE_MAX)) begin
      level = int'(CODE_MAX);
    end
    return level[CODE_W-1:0];
  endfunction

  // Codes of one sample tick; restart reloads first, synthesis advances after
  function automatic out_item_t predict_codes(in_item_t tick);
    out_item_t res;
    res.test_code = MID_CODE;
    res.ref_code  = MID_CODE;
    if (tick.restart) begin
      ref_acc  = '0;
      test_acc = set_offset;
    end
    case (set_mode)
      MODE_SYNTH: begin
        res.test_code = scaled_code(test_acc, set_test_peak);
        res.ref_code  = scaled_code(ref_acc, set_ref_peak);
        ref_acc  = ref_acc + set_step;
        test_acc = test_acc + set_step;
      end
      MODE_STREAM: begin
        res.test_code = tick.stream_sample[CODE_W-1:0];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic logic [PHASE_W-1:0] pick_wide();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PEAK_W-1:0] pick_peak();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return MAX_PEAK;
      2: return 11'd1;
      default: return PEAK_W'($urandom_range(0, 2047));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= PRINT_CAP) begin
      $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    end
  endtask

  // Hold one register write until accepted; valid stays high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MODE:        set_mode      = data[MODE_W-1:0];
      REG_PHASE_STEP:  set_step      = data;
      REG_REF_PEAK:    set_ref_peak  = data[PEAK_W-1:0];
      REG_TEST_PEAK:   set_test_peak = data[PEAK_W-1:0];
      REG_TEST_OFFSET: set_offset    = data;
      default: begin
      end
    endcase
    reg_writes++;
  endtask

  // Drop the tick valid and wait until every expected result is in
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all registers while idle; unused upper data bits are sometimes set
  task automatic load_settings(input logic [MODE_W-1:0] m, input logic [PHASE_W-1:0] st,
                               input logic [PEAK_W-1:0] rp, input logic [PEAK_W-1:0] tp,
                               input logic [PHASE_W-1:0] off);
    logic [CFG_DATA_W-1:0] pad;
    wait_idle();
    pad = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) : '0;
    write_reg(REG_MODE, {pad[CFG_DATA_W-1:MODE_W], m});
    write_reg(REG_PHASE_STEP, st);
    write_reg(REG_REF_PEAK, {pad[CFG_DATA_W-1:PEAK_W], rp});
    write_reg(REG_TEST_PEAK, {pad[CFG_DATA_W-1:PEAK_W], tp});
    write_reg(REG_TEST_OFFSET, off);
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)), $urandom);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Send one sample tick, with an optional gap first, and queue its codes
  task automatic send_tick(input logic rs, input logic [SAMPLE_W-1:0] smp);
    in_item_t tick;
    tick.restart       = rs;
    tick.stream_sample = smp;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= tick;
    do @(posedge clk_i); while (!in_ready_o);
    pending_codes.push_back(predict_codes(tick));
    ticks_sent++;
  endtask

  task automatic test_stop_after_reset();
    send_tick(1'b1, 16'hFFFF);
    send_tick(1'b0, 16'h0000);
  endtask

  task automatic test_unused_mode();
    load_settings(MODE_UNUSED, 32'h4000_0000, MAX_PEAK, MAX_PEAK, '0);
    send_tick(1'b1, 16'hFFFF);
    send_tick(1'b0, 16'h1234);
  endtask

  task automatic test_stream_mode();
    load_settings(MODE_STREAM, 32'h4000_0000, MAX_PEAK, MAX_PEAK, 32'h1234_5678);
    send_tick(1'b0, 16'h0000);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b0, 16'hF000);
    send_tick(1'b0, 16'h0FFF);
    send_tick(1'b1, 16'hA5A5);
  endtask

  // Quarter-turn step with full peaks hits top, bottom and both crossings
  task automatic test_synth_quadrants();
    load_settings(MODE_SYNTH, 32'h4000_0000, MAX_PEAK, MAX_PEAK, 32'h4000_0000);
    send_tick(1'b1, 16'h0000);
    repeat (5) send_tick(1'b0, 16'h5A5A);
  endtask

  // All-ones step and offset wrap the accumulators; zero and unit peaks
  task automatic test_synth_extremes();
    load_settings(MODE_SYNTH, '1, '0, 11'd1, '1);
    send_tick(1'b1, 16'hFFFF);
    repeat (3) send_tick(1'b0, 16'h0000);
    load_settings(MODE_SYNTH, 32'h0040_0000, MAX_PEAK, 11'd1, 32'h8000_0000);
    repeat (2) send_tick(1'b0, 16'h8001);
  endtask

  // Restart must reload the phases even in stream and stop modes
  task automatic test_restart_outside_synth();
    load_settings(MODE_STREAM, 32'h1000_0000, 11'd1000, 11'd1500, 32'h2000_0000);
    send_tick(1'b1, 16'h7FFE);
    load_settings(MODE_SYNTH, 32'h1000_0000, 11'd1000, 11'd1500, 32'h2000_0000);
    repeat (2) send_tick(1'b0, 16'h0001);
    load_settings(MODE_STOP, 32'h1000_0000, 11'd1000, 11'd1500, 32'h6000_0000);
    send_tick(1'b1, 16'h0002);
  endtask

  // Runs of ticks under random settings, mostly synthesis; last part without gaps or stalls
  task automatic test_random_phases();
    int                sent;
    int                run_len;
    int                k;
    int                pick;
    bit                lead_restart;
    logic [MODE_W-1:0] m;
    sent = 0;
    while (sent < RANDOM_TICKS) begin
      if (RANDOM_TICKS - sent <= QUIET_TICKS) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        m = MODE_SYNTH;
      end else if (pick < 8) begin
        m = MODE_STREAM;
      end else if (pick == 8) begin
        m = MODE_STOP;
      end else begin
        m = MODE_UNUSED;
      end
      load_settings(m, pick_wide(), pick_peak(), pick_peak(), pick_wide());
      run_len      = $urandom_range(10, 60);
      lead_restart = $urandom_range(0, 1);
      for (k = 0; k < run_len; k++) begin
        send_tick((k == 0 && lead_restart) || ($urandom_range(0, 15) == 0),
                  SAMPLE_W'($urandom));
        sent++;
      end
    end
  endtask

  // Output ready: random stall bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 11);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each output transaction with the oldest expected codes
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_codes.size() == 0) begin
        report_mismatch("unexpected result, test_code", out_data_o.test_code, 0);
      end else begin
        want_codes = pending_codes.pop_front();
        if (out_data_o.test_code !== want_codes.test_code) begin
          report_mismatch("test_code", out_data_o.test_code, want_codes.test_code);
        end
        if (out_data_o.ref_code !== want_codes.ref_code) begin
          report_mismatch("ref_code", out_data_o.ref_code, want_codes.ref_code);
        end
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
        (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results pending", pending_codes.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int unsigned i;
    int unsigned u;
    int unsigned quad;
    int unsigned rem;
    longint      s;
    longint      v;
    // Build the rounded sine table, exact .5 rounding up
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      u    = 4 * i;
      quad = u / TABLE_ENTRIES;
      rem  = u % TABLE_ENTRIES;
      s    = quad[0] ? q30_quarter_sine(TABLE_ENTRIES - rem) : q30_quarter_sine(rem);
      if (quad >= 2) begin
        s = -s;
      end
      v = longint'(MID_CODE) * (64'sd1 <<< 30) + longint'(MAX_PEAK) * s + (64'sd1 <<< 29);
      if (v < 0) begin
        v = 0;
      end
      v = v >>> 30;
      if (v > longint'(CODE_MAX)) begin
        v = longint'(CODE_MAX);
      end
      sine_codes[i] = v[CODE_W-1:0];
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;

    test_stop_after_reset();
    test_unused_mode();
    test_stream_mode();
    test_synth_quadrants();
    test_synth_extremes();
    test_restart_outside_synth();
    test_random_phases();
    wait_idle();

    $display("Covered %0d sample ticks and %0d register writes in all four mode codes,",
             ticks_sent, reg_writes);
    $display("with restarts, wrapping phases and extreme peaks; %0d results checked, %0d errors",
             results_seen, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dds_src_pkg.sv
rtl/dds_src_cfg.sv
rtl/dds_src_front.sv
rtl/dds_src_fifo.sv
rtl/dds_src_back.sv
rtl/dual_channel_dds_sine_source.sv
rtl/dds_src_checker.sv
tb/dual_channel_dds_sine_source_test.sv
